### src/triangle_normal_area_centroid_unit_defines.svh
// Assertion macros for the triangle normal, area and centroid unit.
// Used by the port checker; no other dependencies.
`ifndef TRIANGLE_NORMAL_AREA_CENTROID_UNIT_DEFINES_SVH
`define TRIANGLE_NORMAL_AREA_CENTROID_UNIT_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define TNAC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next.
`define TNAC_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/tnac_pkg.sv
// Shared constants and control types for the triangle normal/area/centroid unit.
// No dependencies.
`timescale 1ns / 1ps

package tnac_pkg;

    localparam int MAG_BITS     = 52;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = 2;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### src/tnac_if.sv
// Valid/ready channel interfaces for triangle words in and result words out.
// Depends on tnac_pkg for the magnitude width.
`timescale 1ns / 1ps

interface tnac_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tnac_out_if #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
);
    import tnac_pkg::*;
    logic                               valid;
    logic                               ready;
    logic signed [COORD_BITS-1:0]       centroid_x;
    logic signed [COORD_BITS-1:0]       centroid_y;
    logic signed [COORD_BITS-1:0]       centroid_z;
    logic signed [NORMAL_FRAC_BITS+1:0] normal_x;
    logic signed [NORMAL_FRAC_BITS+1:0] normal_y;
    logic signed [NORMAL_FRAC_BITS+1:0] normal_z;
    logic        [MAG_BITS-1:0]         cross_magnitude;
    logic                               degenerate;

    modport source (output valid, centroid_x, centroid_y, centroid_z, normal_x, normal_y,
                    normal_z, cross_magnitude, degenerate, input ready);
    modport sink   (input valid, centroid_x, centroid_y, centroid_z, normal_x, normal_y,
                    normal_z, cross_magnitude, degenerate, output ready);
endinterface

### src/tnac_front.sv
// Front end: accepts triangle words, forms edges, cross terms and centroids.
// Depends on tnac_pkg and tnac_in_if; feeds tnac_queue.
`timescale 1ns / 1ps

module tnac_front
    import tnac_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tnac_in_if.sink           i_tri,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output logic [3*(2*COORD_BITS+3)+3*COORD_BITS-1:0] o_entry
);

    localparam int C  = COORD_BITS;
    localparam int W  = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int NW = 2 * C + 3;
    localparam logic [W-1:0] RECIP3 = W'(((64'd1) << W) / 64'd3);

    logic en;
    logic r_v1, r_v2;

    logic signed [C:0]   r_u [0:2];
    logic signed [C:0]   r_w [0:2];
    logic signed [C+1:0] r_sum [0:2];

    logic signed [PW-1:0] r_p [0:5];
    logic        [W-1:0]  r_cmag [0:2];
    logic        [2*W-1:0] r_cprod [0:2];
    logic                 r_cneg [0:2];

    logic [C-1:0]  w_a [0:2];
    logic [C-1:0]  w_b [0:2];
    logic [C-1:0]  w_c [0:2];
    logic [NW-1:0] w_n [0:2];
    logic [C-1:0]  w_cen [0:2];

    // advance while the last stage is empty or the queue has room
    assign en          = !r_v2 || !i_q_stat.full;
    assign i_tri.ready = en;
    assign o_push      = r_v2 && en;

    assign w_a[0] = i_tri.ax;  assign w_a[1] = i_tri.ay;       assign w_a[2] = i_tri.az;
    assign w_b[0] = i_tri.bx;  assign w_b[1] = i_tri.by_coord; assign w_b[2] = i_tri.bz;
    assign w_c[0] = i_tri.cx;  assign w_c[1] = i_tri.cy;       assign w_c[2] = i_tri.cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_tri.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i]   <= {w_b[i][C-1], w_b[i]} - {w_a[i][C-1], w_a[i]};
                r_w[i]   <= {w_c[i][C-1], w_c[i]} - {w_a[i][C-1], w_a[i]};
                r_sum[i] <= {{2{w_a[i][C-1]}}, w_a[i]} + {{2{w_b[i][C-1]}}, w_b[i]}
                          + {{2{w_c[i][C-1]}}, w_c[i]};
            end
        end
    end

    // cross product partial terms and reciprocal multiply for the divide by three
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= r_u[1] * r_w[2];
            r_p[1] <= r_u[2] * r_w[1];
            r_p[2] <= r_u[2] * r_w[0];
            r_p[3] <= r_u[0] * r_w[2];
            r_p[4] <= r_u[0] * r_w[1];
            r_p[5] <= r_u[1] * r_w[0];
            for (int i = 0; i < 3; i++) begin
                r_cneg[i]  <= r_sum[i][C+1];
                r_cmag[i]  <= r_sum[i][C+1] ? W'(-r_sum[i]) : W'(r_sum[i]);
                r_cprod[i] <= (r_sum[i][C+1] ? W'(-r_sum[i]) : W'(r_sum[i])) * RECIP3;
            end
        end
    end

    always_comb begin
        logic [W-1:0] q0;
        logic [W+1:0] rem;
        logic [W-1:0] q;
        for (int i = 0; i < 3; i++) begin
            w_n[i] = {r_p[2*i][PW-1], r_p[2*i]} - {r_p[2*i+1][PW-1], r_p[2*i+1]};
        end
        for (int i = 0; i < 3; i++) begin
            q0  = r_cprod[i][2*W-1:W];
            rem = {2'b00, r_cmag[i]} - ({q0, 1'b0} + {1'b0, q0});
            // estimate is low by at most one
            q   = (rem >= (W+2)'(3)) ? q0 + 1'b1 : q0;
            w_cen[i] = r_cneg[i] ? C'(-q) : C'(q);
        end
    end

    assign o_entry = {w_n[2], w_n[1], w_n[0], w_cen[2], w_cen[1], w_cen[0]};

endmodule

### src/tnac_queue.sv
// Short register FIFO between front and back ends.
// Depends on tnac_pkg for depth and control structs.
`timescale 1ns / 1ps

module tnac_queue
    import tnac_pkg::*;
#(
    parameter int ENTRY_BITS = 207
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_ctrl               i_ctrl,
    input  logic [ENTRY_BITS-1:0] i_wdata,
    output t_q_stat               o_stat,
    output logic [ENTRY_BITS-1:0] o_rdata
);

    logic [ENTRY_BITS-1:0] r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_BITS-1:0] r_wr, r_rd;
    logic [Q_PTR_BITS:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rdata      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctrl.push) r_wr <= r_wr + 1'b1;
            if (i_ctrl.pop)  r_rd <= r_rd + 1'b1;
            unique case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) r_mem[r_wr] <= i_wdata;
    end

endmodule

### src/tnac_back.sv
// Back end: squares, bit-serial square root and normal quotient stages, output word.
// Depends on tnac_pkg and tnac_out_if; drains tnac_queue.
`timescale 1ns / 1ps

module tnac_back
    import tnac_pkg::*;
#(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  logic [3*(2*COORD_BITS+3)+3*COORD_BITS-1:0] i_entry,
    output logic    o_pop,
    tnac_out_if.source o_res
);

    localparam int C    = COORD_BITS;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int NW   = 2 * C + 3;
    localparam int MW   = 2 * C + 2;
    localparam int H    = C + 1;
    localparam int SW   = 2 * MW;
    localparam int SUMW = SW + 2;
    localparam int RB   = SUMW / 2;
    localparam int QB   = F + 1;
    localparam int DW   = SUMW + 2 * F + 2;
    localparam int L    = (RB > QB) ? RB : QB;

    logic en;

    // squaring stages
    logic          r_v0, r_v1;
    logic [2*H-1:0] r_hh [0:2];
    logic [2*H-1:0] r_hl [0:2];
    logic [2*H-1:0] r_ll [0:2];
    logic [2:0]    r_sg0, r_sg1;
    logic [3*C-1:0] r_cen0, r_cen1;
    logic [SW-1:0] r_sq [0:2];

    // iteration stages, index 0 loaded from the squares
    logic [SUMW-1:0] r_s    [0:L];
    logic [SUMW-1:0] r_rem  [0:L];
    logic [RB-1:0]   r_root [0:L];
    logic [QB-1:0]   r_q    [0:L][0:2];
    logic [DW-1:0]   r_dp   [0:L][0:2];
    logic [DW-1:0]   r_dqs  [0:L][0:2];
    logic [DW-1:0]   r_rr   [0:L][0:2];
    logic [2:0]      r_sg   [0:L];
    logic [3*C-1:0]  r_cen  [0:L];
    logic            r_v    [0:L];

    logic r_ov;

    assign en    = !r_ov || o_res.ready;
    assign o_pop = en && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= o_pop;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] n;
        logic [MW-1:0] m;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n = i_entry[3*C + i*NW +: NW];
                m = n[NW-1] ? MW'(~n + NW'(1)) : MW'(n);
                r_sg0[i] <= n[NW-1];
                r_hh[i]  <= m[MW-1:H] * m[MW-1:H];
                r_hl[i]  <= m[MW-1:H] * m[H-1:0];
                r_ll[i]  <= m[H-1:0] * m[H-1:0];
            end
            r_cen0 <= i_entry[3*C-1:0];
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= ({r_hh[i], {(2*H){1'b0}}} + {{(H-1){1'b0}}, r_hl[i], {(H+1){1'b0}}})
                         + {{(2*H){1'b0}}, r_ll[i]};
            end
            r_sg1  <= r_sg0;
            r_cen1 <= r_cen0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0]    <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
            r_rem[0]  <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
            r_root[0] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_q[0][i]   <= '0;
                r_dp[0][i]  <= '0;
                r_dqs[0][i] <= '0;
                r_rr[0][i]  <= DW'(r_sq[i]) << (2 * F);
            end
            r_sg[0]  <= r_sg1;
            r_cen[0] <= r_cen1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= r_v1;
        end
    end

    for (genvar j = 0; j < L; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s[j+1]   <= r_s[j];
                r_sg[j+1]  <= r_sg[j];
                r_cen[j+1] <= r_cen[j];
            end
        end

        if (j < RB) begin : g_root
            localparam int K = RB - 1 - j;
            logic [SUMW+1:0] w_t;
            logic            w_ge;
            // next root bit: (r + 2^K)^2 - r^2 against the remainder
            assign w_t  = ((SUMW+2)'(r_root[j]) << (K + 1)) | ((SUMW+2)'(1) << (2 * K));
            assign w_ge = ({2'b00, r_rem[j]} >= w_t);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[j+1]  <= w_ge ? SUMW'({2'b00, r_rem[j]} - w_t) : r_rem[j];
                    r_root[j+1] <= w_ge ? (r_root[j] | (RB'(1) << K)) : r_root[j];
                end
            end
        end else begin : g_root_hold
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
            end
        end

        for (genvar i = 0; i < 3; i++) begin : g_comp
            if (j < QB) begin : g_div
                localparam int K = F - j;
                logic [DW:0] w_t;
                logic        w_ok;
                // trial (q + 2^K)^2 * s built from q^2*s and q*s
                assign w_t  = ({1'b0, r_dp[j][i]} + ({1'b0, r_dqs[j][i]} << (K + 1)))
                            + ((DW+1)'(r_s[j]) << (2 * K));
                assign w_ok = (w_t <= {1'b0, r_rr[j][i]});
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_rr[j+1][i]  <= r_rr[j][i];
                        r_dp[j+1][i]  <= w_ok ? DW'(w_t) : r_dp[j][i];
                        r_dqs[j+1][i] <= w_ok ? r_dqs[j][i] + (DW'(r_s[j]) << K)
                                              : r_dqs[j][i];
                        r_q[j+1][i]   <= w_ok ? (r_q[j][i] | (QB'(1) << K)) : r_q[j][i];
                    end
                end
            end else begin : g_div_hold
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_rr[j+1][i]  <= r_rr[j][i];
                        r_dp[j+1][i]  <= r_dp[j][i];
                        r_dqs[j+1][i] <= r_dqs[j][i];
                        r_q[j+1][i]   <= r_q[j][i];
                    end
                end
            end
        end
    end

    // magnitude, saturating when the root is wider than the port
    logic [MAG_BITS-1:0] w_mag;
    if (RB > MAG_BITS) begin : g_sat
        assign w_mag = (|r_root[L][RB-1:MAG_BITS]) ? {MAG_BITS{1'b1}}
                                                  : r_root[L][MAG_BITS-1:0];
    end else begin : g_nosat
        assign w_mag = MAG_BITS'(r_root[L]);
    end

    logic          w_deg;
    logic [F+1:0]  w_nrm [0:2];
    assign w_deg = (r_s[L] == '0);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nrm[i] = w_deg ? '0 : (r_sg[L][i] ? (F+2)'(-{1'b0, r_q[L][i]})
                                                : (F+2)'({1'b0, r_q[L][i]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.centroid_x      <= r_cen[L][C-1:0];
            o_res.centroid_y      <= r_cen[L][2*C-1:C];
            o_res.centroid_z      <= r_cen[L][3*C-1:2*C];
            o_res.normal_x        <= w_nrm[0];
            o_res.normal_y        <= w_nrm[1];
            o_res.normal_z        <= w_nrm[2];
            o_res.cross_magnitude <= w_deg ? '0 : w_mag;
            o_res.degenerate      <= w_deg;
        end
    end

    assign o_res.valid = r_ov;

endmodule

### src/triangle_normal_area_centroid_unit.sv
// Triangle face normal, doubled area and centroid, one triangle word per cycle while results are taken.
// Throughput: one word per cycle while the result channel is ready; the square root (one bit per stage) sets the depth.
// Reset (synchronous, active low) clears all valid flags and queue pointers.
`timescale 1ns / 1ps

module triangle_normal_area_centroid_unit
    import tnac_pkg::*;
#(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tnac_in_if.sink    i_tri,
    tnac_out_if.source o_res
);

    localparam int ENTRY_BITS = 3 * (2 * COORD_BITS + 3) + 3 * COORD_BITS;

    t_q_ctrl               w_q_ctrl;
    t_q_stat               w_q_stat;
    logic [ENTRY_BITS-1:0] w_wdata;
    logic [ENTRY_BITS-1:0] w_rdata;

    // Front: hold input word, form edges and cross terms, divide sums by three.
    tnac_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tri    (i_tri),
        .i_q_stat (w_q_stat),
        .o_push   (w_q_ctrl.push),
        .o_entry  (w_wdata)
    );

    // Queue: decouple front stalls from back stalls.
    tnac_queue #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_q_ctrl),
        .i_wdata (w_wdata),
        .o_stat  (w_q_stat),
        .o_rdata (w_rdata)
    );

    // Back: square the cross product, take its root and the unit normal.
    tnac_back #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_entry  (w_rdata),
        .o_pop    (w_q_ctrl.pop),
        .o_res    (o_res)
    );

endmodule

### src/tnac_checker.sv
// Port checker for the triangle unit, attached by bind.
// Depends on tnac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "triangle_normal_area_centroid_unit_defines.svh"

module tnac_checker
    import tnac_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_degenerate,
    input logic [NORMAL_FRAC_BITS+1:0] i_normal_x,
    input logic [NORMAL_FRAC_BITS+1:0] i_normal_y,
    input logic [NORMAL_FRAC_BITS+1:0] i_normal_z,
    input logic [MAG_BITS-1:0]         i_cross_magnitude
);

    `TNAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped while stalled")
    `TNAC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_cross_magnitude) && $stable(i_degenerate), "stalled result word changed")
    `TNAC_ASSERT(a_degen_zero, i_clk, i_rst_n, !(i_out_valid && i_degenerate) || (i_cross_magnitude == '0 && i_normal_x == '0 && i_normal_y == '0 && i_normal_z == '0), "degenerate word has nonzero normal or magnitude")
    `TNAC_ASSERT(a_live_mag, i_clk, i_rst_n, !(i_out_valid && !i_degenerate) || (i_cross_magnitude != '0), "live triangle with zero magnitude")

endmodule

bind triangle_normal_area_centroid_unit tnac_checker #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tnac_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_degenerate      (o_res.degenerate),
    .i_normal_x        (o_res.normal_x),
    .i_normal_y        (o_res.normal_y),
    .i_normal_z        (o_res.normal_z),
    .i_cross_magnitude (o_res.cross_magnitude)
);

### tb/triangle_normal_area_centroid_unit_tb.sv
// Self-checking bench for the triangle normal, doubled area and centroid unit.
// Depends on tnac_pkg, the tnac_in_if / tnac_out_if channels and the unit itself.
`timescale 1ns / 1ps

module triangle_normal_area_centroid_unit_tb;
    import tnac_pkg::*;

    localparam int CB = 24;
    localparam int NF = 14;

    typedef logic signed [CB-1:0] t_coord;

    // One triangle word: three vertices, x/y/z each.
    typedef struct packed {
        t_coord ax, ay, az;
        t_coord bx, by_c, bz;
        t_coord cx, cy, cz;
    } t_face_in;

    // One result word, in port order.
    typedef struct packed {
        t_coord                ctr_x, ctr_y, ctr_z;
        logic signed [NF+1:0]  nrm_x, nrm_y, nrm_z;
        logic [MAG_BITS-1:0]   mag;
        logic                  degen;
    } t_face_res;

    // Directed row: a word plus an optional hand-written result.
    typedef struct packed {
        t_face_in  face;
        logic      typed;
        t_face_res want;
    } t_face_row;

    localparam t_coord MX = 24'sh7FFFFF;
    localparam t_coord MN = 24'sh800000;
    localparam t_coord ONE = 24'sd256;
    localparam logic signed [NF+1:0] UNIT_P = 16'sd16384;
    localparam logic signed [NF+1:0] UNIT_N = -16'sd16384;
    localparam t_face_res NO_RES = '0;

    localparam int DIR_COUNT = 12;
    localparam t_face_row DIR_ROWS [DIR_COUNT] = '{
        // all vertices at the origin: zero cross product
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b1}},
        // every coordinate at its maximum
        '{'{MX, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b1, '{MX, MX, MX, 0, 0, 0, 0, 1'b1}},
        // every coordinate at its minimum
        '{'{MN, MN, MN, MN, MN, MN, MN, MN, MN}, 1'b1, '{MN, MN, MN, 0, 0, 0, 0, 1'b1}},
        // unit right triangle in the xy plane, normal along +z
        '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1'b1,
          '{85, 85, 0, 0, 0, UNIT_P, 52'd65536, 1'b0}},
        // same triangle wound the other way, normal along -z
        '{'{0, 0, 0, 0, ONE, 0, ONE, 0, 0}, 1'b1,
          '{85, 85, 0, 0, 0, UNIT_N, 52'd65536, 1'b0}},
        // unit triangle in the yz plane, normal along +x
        '{'{0, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
          '{0, 85, 85, UNIT_P, 0, 0, 52'd65536, 1'b0}},
        // collinear vertices
        '{'{1, 2, 3, 2, 4, 6, 3, 6, 9}, 1'b1, '{2, 4, 6, 0, 0, 0, 0, 1'b1}},
        // repeated vertex with other vertex away
        '{'{-5, 7, 1000, -5, 7, 1000, 300, -9, 4}, 1'b0, NO_RES},
        // widest spread along two axes
        '{'{MN, MN, MN, MX, MN, MN, MN, MX, MN}, 1'b0, NO_RES},
        // widest spread on all three axes
        '{'{MN, MN, MN, MX, MX, MN, MN, MX, MX}, 1'b0, NO_RES},
        // negative sums that truncate toward zero
        '{'{-1, -2, -4, 0, 0, 0, 0, -1, 1}, 1'b0, NO_RES},
        // skewed triangle, all normal components nonzero
        '{'{MX, 0, MN, 0, MN, MX, MN, MX, 0}, 1'b0, NO_RES}
    };

    logic i_clk;
    logic i_rst_n;

    tnac_in_if  #(.COORD_BITS(CB))                       tri_in ();
    tnac_out_if #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NF)) res_out ();

    triangle_normal_area_centroid_unit #(
        .COORD_BITS(CB),
        .NORMAL_FRAC_BITS(NF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_in),
        .o_res   (res_out)
    );

    t_face_res pending_res[$];
    int        err_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_req;
    int        quiet_cycles;

    // Exact unit behavior: edges from A, cross product, floor sqrt of |N|^2,
    // truncated unit normal and centroid by truncating division.
    function automatic t_face_res predict_face(t_face_in f);
        longint          ux, uy, uz, vx, vy, vz;
        longint          n [3];
        logic [63:0]     absn;
        logic [127:0]    wide, len_sq, c128;
        logic [63:0]     root, cand;
        logic [159:0]    lhs, rhs, t;
        logic [NF+1:0]   q, qc;
        logic [NF+1:0]   comp [3];
        t_face_res       r;
        ux = longint'(f.bx) - longint'(f.ax);
        uy = longint'(f.by_c) - longint'(f.ay);
        uz = longint'(f.bz) - longint'(f.az);
        vx = longint'(f.cx) - longint'(f.ax);
        vy = longint'(f.cy) - longint'(f.ay);
        vz = longint'(f.cz) - longint'(f.az);
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        r = '0;
        r.ctr_x = t_coord'((longint'(f.ax) + longint'(f.bx) + longint'(f.cx)) / 3);
        r.ctr_y = t_coord'((longint'(f.ay) + longint'(f.by_c) + longint'(f.cy)) / 3);
        r.ctr_z = t_coord'((longint'(f.az) + longint'(f.bz) + longint'(f.cz)) / 3);
        len_sq = '0;
        for (int i = 0; i < 3; i++) begin
            absn = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
            wide = 128'(absn);
            len_sq = len_sq + wide * wide;
        end
        if (len_sq == 0) begin
            r.degen = 1'b1;
            return r;
        end
        root = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = root | (64'd1 << k);
            c128 = 128'(cand);
            if (c128 * c128 <= len_sq) root = cand;
        end
        r.mag = root[MAG_BITS-1:0];
        for (int i = 0; i < 3; i++) begin
            absn = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
            t = 160'(absn) << NF;
            rhs = t * t;
            q = '0;
            for (int k = NF; k >= 0; k--) begin
                qc = q | (16'd1 << k);
                lhs = 160'(qc) * 160'(qc) * 160'(len_sq);
                if (lhs <= rhs) q = qc;
            end
            comp[i] = (n[i] < 0) ? -q : q;
        end
        r.nrm_x = comp[0];
        r.nrm_y = comp[1];
        r.nrm_z = comp[2];
        return r;
    endfunction

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    // Mostly full-range triangles, some small ones, some degenerate.
    function automatic t_face_in rand_face();
        t_face_in f;
        int       kind;
        kind = $urandom_range(99);
        f = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        if (kind < 30) begin
            f.ax = $signed(12'($urandom)); f.ay = $signed(12'($urandom));
            f.az = $signed(12'($urandom)); f.bx = $signed(12'($urandom));
            f.by_c = $signed(12'($urandom)); f.bz = $signed(12'($urandom));
            f.cx = $signed(12'($urandom)); f.cy = $signed(12'($urandom));
            f.cz = $signed(12'($urandom));
        end else if (kind < 36) begin
            // C on the line through A and B
            f.ax = $signed(20'($urandom)); f.ay = $signed(20'($urandom));
            f.az = $signed(20'($urandom));
            f.bx = f.ax + $signed(16'($urandom)); f.by_c = f.ay + $signed(16'($urandom));
            f.bz = f.az + $signed(16'($urandom));
            f.cx = t_coord'(f.ax + 2 * (f.bx - f.ax));
            f.cy = t_coord'(f.ay + 2 * (f.by_c - f.ay));
            f.cz = t_coord'(f.az + 2 * (f.bz - f.az));
        end else if (kind < 40) begin
            // repeated vertex
            f.cx = f.bx; f.cy = f.by_c; f.cz = f.bz;
        end
        return f;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Present one word at the falling edge and hold it until accepted.
    task automatic send_face(t_face_in f, t_face_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            tri_in.valid = 1'b0;
            @(negedge i_clk);
        end
        tri_in.ax = f.ax; tri_in.ay = f.ay; tri_in.az = f.az;
        tri_in.bx = f.bx; tri_in.by_coord = f.by_c; tri_in.bz = f.bz;
        tri_in.cx = f.cx; tri_in.cy = f.cy; tri_in.cz = f.cz;
        tri_in.valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (tri_in.ready) break;
        end
        pending_res.push_back(want);
        @(negedge i_clk);
        tri_in.valid = 1'b0;
    endtask

    // Hold off until every expected word has come back, plus the pipeline depth.
    task automatic drain_all();
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        res_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_out.ready = 1'b0;
            end else begin
                res_out.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each returned word with the oldest expectation.
    always @(posedge i_clk) begin
        t_face_res want;
        if (i_rst_n && res_out.valid && res_out.ready) begin
            if (pending_res.size() == 0) begin
                $display("%0t unexpected result word, expected none, actual %h", $time,
                         res_out.cross_magnitude);
                err_count++;
            end else begin
                want = pending_res.pop_front();
                check_field("centroid_x", 64'(want.ctr_x), 64'(res_out.centroid_x));
                check_field("centroid_y", 64'(want.ctr_y), 64'(res_out.centroid_y));
                check_field("centroid_z", 64'(want.ctr_z), 64'(res_out.centroid_z));
                check_field("normal_x", 64'(want.nrm_x), 64'(res_out.normal_x));
                check_field("normal_y", 64'(want.nrm_y), 64'(res_out.normal_y));
                check_field("normal_z", 64'(want.nrm_z), 64'(res_out.normal_z));
                check_field("cross_magnitude", 64'(want.mag),
                            64'(res_out.cross_magnitude));
                check_field("degenerate", 64'(want.degen), 64'(res_out.degenerate));
            end
        end
    end

    // Watchdog: give up after a long run with no word moving on either side.
    always @(posedge i_clk) begin
        if ((tri_in.valid && tri_in.ready) || (res_out.valid && res_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_face_in f;
        err_count = 0;
        quiet_cycles = 0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        tri_in.valid = 1'b0;
        {tri_in.ax, tri_in.ay, tri_in.az} = '0;
        {tri_in.bx, tri_in.by_coord, tri_in.bz} = '0;
        {tri_in.cx, tri_in.cy, tri_in.cz} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: take the typed result where given, else predict.
        send_idle_pct = 10;
        recv_idle_pct = 75;
        foreach (DIR_ROWS[i])
            send_face(DIR_ROWS[i].face,
                      DIR_ROWS[i].typed ? DIR_ROWS[i].want : predict_face(DIR_ROWS[i].face));

        // Phase 1: stall the output for a long stretch so the pipe backs up.
        hold_req = 1'b1;
        repeat (600) begin
            f = rand_face();
            send_face(f, predict_face(f));
        end
        drain_all();

        // Phase 2: sender mostly idle, receiver mostly ready.
        send_idle_pct = 75;
        recv_idle_pct = 10;
        repeat (600) begin
            f = rand_face();
            send_face(f, predict_face(f));
        end
        drain_all();

        // Phase 3: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (600) begin
            f = rand_face();
            send_face(f, predict_face(f));
        end
        drain_all();

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
